>>> hdl/kcl_pkg.sv
package kcl_pkg;

  localparam int CODE_DIGITS = 5;
  localparam int CNT_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int KEY_W       = 8;
  localparam int TICKS_W     = 16;
  localparam int ATT_W       = 4;
  localparam int KEYS_OUT_W  = 3;

  localparam logic [KEY_W-1:0]   KEY_OPEN    = 8'h2B;
  localparam logic [KEY_W-1:0]   KEY_CHANGE  = 8'h2D;
  localparam logic [KEY_W-1:0]   KEY_CLOSE   = 8'h0D;
  localparam logic               KIND_TICK   = 1'b1;
  localparam logic [ATT_W-1:0]   ATT_SAT     = 4'hF;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;
  localparam logic [ATT_W-1:0]   ATT_RESET   = 4'd3;

  typedef logic [KEY_W-1:0] code_t [CODE_DIGITS];

  typedef enum logic [3:0] {
    M_SETUP      = 4'd0,
    M_SETUP_CONF = 4'd1,
    M_MENU       = 4'd2,
    M_OPEN_ENTRY = 4'd3,
    M_OLD_ENTRY  = 4'd4,
    M_NEW_ENTRY  = 4'd5,
    M_NEW_CONF   = 4'd6,
    M_DOOR       = 4'd7,
    M_ALARM      = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_MATCH     = 3'd1,
    EV_WRONG     = 3'd2,
    EV_CONF_BAD  = 3'd3,
    EV_SAVED     = 3'd4,
    EV_ALARM_END = 3'd5
  } event_t;

  // register indexes on the config port
  typedef enum logic {
    REG_LOCKOUT_TICKS = 1'b0,
    REG_MAX_ATTEMPTS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TICKS_W-1:0] lockout_ticks;
    logic [ATT_W-1:0]   max_attempts;
  } cfg_t;

  typedef struct packed {
    event_t                event_res;
    logic [KEYS_OUT_W-1:0] keys_entered;
    logic                  alarm_on;
    logic                  door_open;
    mode_t                 mode;
  } result_t;

endpackage

>>> hdl/kcl_cfg.sv
module kcl_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output kcl_pkg::cfg_t     cfg
);

  kcl_pkg::cfg_t     cfg_r;
  kcl_pkg::cfg_t     cfg_nxt;
  kcl_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = kcl_pkg::reg_idx_t'(paddr[2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        kcl_pkg::REG_LOCKOUT_TICKS: cfg_nxt.lockout_ticks = pwdata[kcl_pkg::TICKS_W-1:0];
        kcl_pkg::REG_MAX_ATTEMPTS:  cfg_nxt.max_attempts  = pwdata[kcl_pkg::ATT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      kcl_pkg::REG_LOCKOUT_TICKS:
        prdata = {{(32 - kcl_pkg::TICKS_W){1'b0}}, cfg_r.lockout_ticks};
      kcl_pkg::REG_MAX_ATTEMPTS:
        prdata = {{(32 - kcl_pkg::ATT_W){1'b0}}, cfg_r.max_attempts};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ticks <= kcl_pkg::TICKS_RESET;
      cfg_r.max_attempts  <= kcl_pkg::ATT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/kcl_core.sv
module kcl_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         kind,
  input  logic [kcl_pkg::KEY_W-1:0]    key,
  input  kcl_pkg::cfg_t                cfg,
  output kcl_pkg::result_t             res
);

  localparam logic [kcl_pkg::CNT_W-1:0] CNT_LAST = kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS - 1);

  kcl_pkg::mode_t                  mode_r, mode_nxt;
  logic [kcl_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            valid_r, valid_nxt;
  logic [kcl_pkg::ATT_W-1:0]       wrong_r, wrong_nxt, wrong_inc;
  logic [kcl_pkg::TICKS_W-1:0]     alarm_r, alarm_nxt;
  kcl_pkg::event_t                 ev;

  kcl_pkg::code_t stored_r;
  kcl_pkg::code_t entry_r;
  kcl_pkg::code_t first_r;
  kcl_pkg::code_t entry_new;

  logic wr_entry, wr_first, save;
  logic last_digit, match_stored, match_first;

  // entry as it stands with the current key in place
  always_comb begin
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
      entry_new[i] = (cnt_r == kcl_pkg::CNT_W'(i)) ? key : entry_r[i];
    end
  end

  always_comb begin
    match_stored = valid_r;
    match_first  = 1'b1;
    for (int i = 0; i < kcl_pkg::CODE_DIGITS; i++) begin
      if (entry_new[i] != stored_r[i]) match_stored = 1'b0;
      if (entry_new[i] != first_r[i])  match_first  = 1'b0;
    end
  end

  assign last_digit = (cnt_r == CNT_LAST);
  assign wrong_inc  = (wrong_r == kcl_pkg::ATT_SAT) ? wrong_r : wrong_r + 1'b1;

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    wrong_nxt = wrong_r;
    alarm_nxt = alarm_r;
    ev        = kcl_pkg::EV_NONE;
    wr_entry  = 1'b0;
    wr_first  = 1'b0;
    save      = 1'b0;
    if (kind == kcl_pkg::KIND_TICK) begin
      if (mode_r == kcl_pkg::M_ALARM) begin
        if (alarm_r <= kcl_pkg::TICKS_W'(1)) begin
          alarm_nxt = '0;
          wrong_nxt = '0;
          cnt_nxt   = '0;
          mode_nxt  = kcl_pkg::M_MENU;
          ev        = kcl_pkg::EV_ALARM_END;
        end else begin
          alarm_nxt = alarm_r - 1'b1;
        end
      end
    end else begin
      case (mode_r)
        kcl_pkg::M_SETUP, kcl_pkg::M_NEW_ENTRY: begin
          wr_first = 1'b1;
          cnt_nxt  = last_digit ? '0 : cnt_r + 1'b1;
          if (last_digit) begin
            mode_nxt = (mode_r == kcl_pkg::M_SETUP) ? kcl_pkg::M_SETUP_CONF
                                                     : kcl_pkg::M_NEW_CONF;
          end
        end
        kcl_pkg::M_SETUP_CONF, kcl_pkg::M_NEW_CONF: begin
          wr_entry = 1'b1;
          cnt_nxt  = last_digit ? '0 : cnt_r + 1'b1;
          if (last_digit) begin
            if (match_first) begin
              save      = 1'b1;
              valid_nxt = 1'b1;
              mode_nxt  = kcl_pkg::M_MENU;
              ev        = kcl_pkg::EV_SAVED;
            end else begin
              mode_nxt = (mode_r == kcl_pkg::M_SETUP_CONF) ? kcl_pkg::M_SETUP
                                                            : kcl_pkg::M_NEW_ENTRY;
              ev       = kcl_pkg::EV_CONF_BAD;
            end
          end
        end
        kcl_pkg::M_MENU: begin
          cnt_nxt = '0;
          if (key == kcl_pkg::KEY_OPEN) begin
            mode_nxt = kcl_pkg::M_OPEN_ENTRY;
          end else if (key == kcl_pkg::KEY_CHANGE) begin
            mode_nxt = kcl_pkg::M_OLD_ENTRY;
          end
        end
        kcl_pkg::M_OPEN_ENTRY, kcl_pkg::M_OLD_ENTRY: begin
          wr_entry = 1'b1;
          cnt_nxt  = last_digit ? '0 : cnt_r + 1'b1;
          if (last_digit) begin
            if (match_stored) begin
              wrong_nxt = '0;
              mode_nxt  = (mode_r == kcl_pkg::M_OPEN_ENTRY) ? kcl_pkg::M_DOOR
                                                             : kcl_pkg::M_NEW_ENTRY;
              ev        = kcl_pkg::EV_MATCH;
            end else begin
              wrong_nxt = wrong_inc;
              ev        = kcl_pkg::EV_WRONG;
              if (wrong_inc >= cfg.max_attempts) begin
                mode_nxt  = kcl_pkg::M_ALARM;
                alarm_nxt = cfg.lockout_ticks;
              end
            end
          end
        end
        kcl_pkg::M_DOOR: begin
          if (key == kcl_pkg::KEY_CLOSE) mode_nxt = kcl_pkg::M_MENU;
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // result fields
  always_comb begin
    res.mode         = mode_nxt;
    res.door_open    = (mode_nxt == kcl_pkg::M_DOOR);
    res.alarm_on     = (mode_nxt == kcl_pkg::M_ALARM);
    res.keys_entered = kcl_pkg::KEYS_OUT_W'(cnt_nxt);
    res.event_res    = ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= kcl_pkg::M_SETUP;
      cnt_r   <= '0;
      valid_r <= 1'b0;
      wrong_r <= '0;
      alarm_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      wrong_r <= wrong_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (wr_entry) entry_r[cnt_r] <= key;
      if (wr_first) first_r[cnt_r] <= key;
      if (save)     stored_r       <= first_r;
    end
  end

endmodule

>>> hdl/keypad_code_lock_controller.sv
// keypad code lock with lockout alarm
// input channel: one item per key press or time tick; in_tuser[0] is the kind
//   (0 key press, 1 tick), in_tdata[7:0] the key code (ignored for ticks)
// result channel: exactly one item per input item, in order, carrying the
//   mode, door and alarm flags, the digit count of the current entry and the
//   event that the input item caused
// config port: apb-style, lockout_ticks at 0x0, max_attempts at 0x4; write
//   only while the lock is idle; pready is tied high
// timing: an item is held in the input register; the state update and
//   five-byte code compare run between that register and the result
//   register, which takes the item when it is empty or being read; one item
//   per cycle sustained while the receiver takes every result
// reset: no code stored, setup entry mode, attempt and alarm counters cleared,
//   config back to 1000 ticks and 3 attempts
// when the receiver stalls, the result register holds, the input register
//   still takes one more item, then in_tready drops until the result is taken
module keypad_code_lock_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key
  input  logic [0:0]  in_tuser,   // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] mode, [4] door_open, [5] alarm_on,
                                  // [8:6] keys_entered, [11:9] event_res, [15:12] zero
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  kcl_pkg::cfg_t    cfg;
  kcl_pkg::result_t res;
  kcl_pkg::result_t res_r;

  logic                      in_valid_r;
  logic                      kind_r;
  logic [kcl_pkg::KEY_W-1:0] key_r;
  logic                      out_valid_r;
  logic                      advance;

  assign cfg_pready = 1'b1;

  kcl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // item moves from input register into result register
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  kcl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .kind  (kind_r),
    .key   (key_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r <= in_tuser[0];
      key_r  <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r};

endmodule

>>> tb/tb_keypad_code_lock_controller.sv
`timescale 1ns / 100ps

module tb_keypad_code_lock_controller;
  import kcl_pkg::*;

  localparam int PIPE_LAT    = 1;       // acceptance to result, in cycles
  localparam int CYCLE_LIMIT = 60_000;

  // dut ports; those the bench drives are known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;  // [7:0] key
  logic [0:0]  in_tuser    = '0;  // [0] kind
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;         // [3:0] mode, [4] door_open, [5] alarm_on,
                                  // [8:6] keys_entered, [11:9] event_res
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // bookkeeping
  int          errors      = 0;
  int          cycle_cnt   = 0;
  bit          steady_flow = 1'b0;  // no idling on either side while set
  result_t     status_queue[$];     // lock status expected for each accepted item

  // mirror of the lock state
  code_t       saved_code;
  code_t       typed_code;
  code_t       first_code;
  bit          code_set;
  int unsigned digit_cnt;
  mode_t       lock_st;
  int unsigned wrong_cnt;
  int unsigned alarm_left;
  logic [15:0] cfg_lockout;
  logic [3:0]  cfg_max;
  event_t      last_ev;

  // plan for the entry being typed in the random part
  bit          entry_ok;
  bit          entry_wild;
  int unsigned entry_bad_pos;

  // code used by the directed part: every special key doubles as a digit
  code_t       dir_code = '{8'h00, 8'hFF, KEY_OPEN, KEY_CHANGE, KEY_CLOSE};

  keypad_code_lock_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure: ready is low about 23 times in a hundred, never during steady flow
  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(0, 99) >= 23);
  end

  // ---------------------------------------------------------------------------
  // lock state mirror
  // ---------------------------------------------------------------------------

  task automatic lock_mirror_reset();
    code_set    = 1'b0;
    digit_cnt   = 0;
    lock_st     = M_SETUP;
    wrong_cnt   = 0;
    alarm_left  = 0;
    cfg_lockout = TICKS_RESET;
    cfg_max     = ATT_RESET;
    last_ev     = EV_NONE;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      saved_code[i] = '0;
      typed_code[i] = '0;
      first_code[i] = '0;
    end
  endtask

  function automatic bit codes_equal(input code_t a, input code_t b);
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (a[i] != b[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // store one digit, report a full entry and restart the count
  function automatic bit add_digit(input bit to_first, input logic [7:0] key);
    bit full;
    if (to_first) first_code[digit_cnt] = key;
    else typed_code[digit_cnt] = key;
    digit_cnt++;
    full = (digit_cnt >= CODE_DIGITS);
    if (full) digit_cnt = 0;
    return full;
  endfunction

  // compare the typed entry with the stored code, count misses toward the alarm
  function automatic event_t verify_code(input mode_t match_mode);
    if (code_set && codes_equal(typed_code, saved_code)) begin
      wrong_cnt = 0;
      lock_st   = match_mode;
      return EV_MATCH;
    end
    if (wrong_cnt < ATT_SAT) wrong_cnt++;
    if (wrong_cnt >= cfg_max) begin
      lock_st    = M_ALARM;
      alarm_left = 32'(cfg_lockout);
    end
    return EV_WRONG;
  endfunction

  // second entry of a new code: save on match, else type the code again
  function automatic event_t confirm_code(input mode_t retry_mode);
    if (codes_equal(typed_code, first_code)) begin
      saved_code = first_code;
      code_set   = 1'b1;
      lock_st    = M_MENU;
      return EV_SAVED;
    end
    lock_st = retry_mode;
    return EV_CONF_BAD;
  endfunction

  task automatic lock_predict(input logic kind, input logic [7:0] key);
    event_t  ev;
    result_t st;
    ev = EV_NONE;
    if (kind == KIND_TICK) begin
      // ticks only matter while the alarm sounds
      if (lock_st == M_ALARM) begin
        if (alarm_left <= 1) begin
          alarm_left = 0;
          wrong_cnt  = 0;
          digit_cnt  = 0;
          lock_st    = M_MENU;
          ev         = EV_ALARM_END;
        end else begin
          alarm_left--;
        end
      end
    end else begin
      case (lock_st)
        M_SETUP: begin
          if (add_digit(1'b1, key)) lock_st = M_SETUP_CONF;
        end
        M_SETUP_CONF: begin
          if (add_digit(1'b0, key)) ev = confirm_code(M_SETUP);
        end
        M_MENU: begin
          digit_cnt = 0;
          if (key == KEY_OPEN) lock_st = M_OPEN_ENTRY;
          else if (key == KEY_CHANGE) lock_st = M_OLD_ENTRY;
        end
        M_OPEN_ENTRY: begin
          if (add_digit(1'b0, key)) ev = verify_code(M_DOOR);
        end
        M_OLD_ENTRY: begin
          if (add_digit(1'b0, key)) ev = verify_code(M_NEW_ENTRY);
        end
        M_NEW_ENTRY: begin
          if (add_digit(1'b1, key)) lock_st = M_NEW_CONF;
        end
        M_NEW_CONF: begin
          if (add_digit(1'b0, key)) ev = confirm_code(M_NEW_ENTRY);
        end
        M_DOOR: begin
          if (key == KEY_CLOSE) lock_st = M_MENU;
        end
        default: begin
          // keys during the alarm do nothing
        end
      endcase
    end
    st.mode         = lock_st;
    st.door_open    = (lock_st == M_DOOR);
    st.alarm_on     = (lock_st == M_ALARM);
    st.keys_entered = 3'(digit_cnt);
    st.event_res    = ev;
    status_queue.push_back(st);
    last_ev = ev;
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_queue.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing actual %h",
                 $time, out_tdata);
      end else begin
        want = status_queue.pop_front();
        got  = out_tdata[11:0];
        compare_field("mode", 16'(want.mode), 16'(got.mode));
        compare_field("door_open", 16'(want.door_open), 16'(got.door_open));
        compare_field("alarm_on", 16'(want.alarm_on), 16'(got.alarm_on));
        compare_field("keys_entered", 16'(want.keys_entered), 16'(got.keys_entered));
        compare_field("event_res", 16'(want.event_res), 16'(got.event_res));
        compare_field("pad bits", 16'd0, 16'(out_tdata[15:12]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one item on the input channel; valid is left high so back-to-back items
  // need no second assignment within a step
  task automatic send_item(input logic kind, input logic [7:0] key);
    while (!steady_flow && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= kind;
    in_tdata    <= key;
    do @(posedge clk); while (!in_tready);
    lock_predict(kind, key);
  endtask

  task automatic send_code(input code_t digits);
    for (int i = 0; i < CODE_DIGITS; i++) send_item(1'b0, digits[i]);
  endtask

  // stop sending and wait until every item has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // both registers, back to back, setup then access phase each
  task automatic cfg_apply(input logic [15:0] ticks, input logic [3:0] att);
    logic [31:0] vals [2];
    vals[REG_LOCKOUT_TICKS] = {16'd0, ticks};
    vals[REG_MAX_ATTEMPTS]  = {28'd0, att};
    for (int i = 0; i < 2; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {reg_idx_t'(i), 2'b00};
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_lockout = ticks;
    cfg_max     = att;
    @(posedge clk);
  endtask

  // random key, leaning toward the keys the lock treats specially
  function automatic logic [7:0] any_key();
    case ($urandom_range(0, 11))
      0: return KEY_OPEN;
      1: return KEY_CHANGE;
      2: return KEY_CLOSE;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one item chosen from the current lock mode: mostly well-formed entries,
  // with near misses, wild entries, stray ticks and ignored keys mixed in
  task automatic random_item(input int pct_good, output bit meaningful);
    logic       kind;
    logic [7:0] key;
    int         roll;
    code_t      target;
    kind       = 1'b0;
    key        = any_key();
    meaningful = 1'b1;
    roll       = $urandom_range(0, 99);
    case (lock_st)
      M_SETUP, M_NEW_ENTRY: begin
        if (roll < 4) begin
          kind       = KIND_TICK;
          meaningful = 1'b0;
        end
      end
      M_SETUP_CONF, M_NEW_CONF, M_OPEN_ENTRY, M_OLD_ENTRY: begin
        if (digit_cnt == 0) begin
          if (lock_st == M_SETUP_CONF || lock_st == M_NEW_CONF)
            entry_ok = ($urandom_range(0, 99) < 75);
          else
            entry_ok = ($urandom_range(0, 99) < pct_good);
          entry_bad_pos = $urandom_range(0, CODE_DIGITS - 1);
          entry_wild    = ($urandom_range(0, 3) == 0);
        end
        if (lock_st == M_OPEN_ENTRY || lock_st == M_OLD_ENTRY) target = saved_code;
        else target = first_code;
        if (roll < 4) begin
          kind       = KIND_TICK;
          meaningful = 1'b0;
        end else if (entry_ok || (!entry_wild && digit_cnt != entry_bad_pos)) begin
          key = target[digit_cnt];
        end else if (!entry_wild) begin
          // one digit off
          key = target[digit_cnt] ^ 8'($urandom_range(1, 255));
        end
      end
      M_MENU: begin
        if (roll < 45) key = KEY_OPEN;
        else if (roll < 80) key = KEY_CHANGE;
        else if (roll < 90) meaningful = 1'b0;
        else begin
          kind       = KIND_TICK;
          meaningful = 1'b0;
        end
      end
      M_DOOR: begin
        if (roll < 75) key = KEY_CLOSE;
        else if (roll < 92) meaningful = 1'b0;
        else begin
          kind       = KIND_TICK;
          meaningful = 1'b0;
        end
      end
      default: begin
        // alarm: mostly ticks, a few ignored keys
        if (roll < 85) kind = KIND_TICK;
        else meaningful = 1'b0;
      end
    endcase
    send_item(kind, key);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset config: first code with special keys as digits, stray tick, menu
  // noise, then a wrong code that leaves room for a retry
  task automatic test_setup_and_retry();
    code_t near_miss;
    near_miss    = dir_code;
    near_miss[4] = dir_code[4] ^ 8'h01;
    send_code(dir_code);
    send_item(KIND_TICK, 8'hA5);
    send_code(dir_code);
    send_item(1'b0, 8'h41);
    send_item(1'b0, KEY_OPEN);
    send_code(near_miss);
  endtask

  // zero lockout: second wrong code raises the alarm, a key is ignored and
  // the first tick ends it
  task automatic test_zero_lockout();
    code_t wrong_code;
    drain_results();
    cfg_apply(16'd0, 4'd2);
    for (int i = 0; i < CODE_DIGITS; i++) wrong_code[i] = 8'h5A;
    send_code(wrong_code);
    send_item(1'b0, KEY_CLOSE);
    send_item(KIND_TICK, 8'h00);
  endtask

  // open with the right code, ignored key and tick at the door, then close
  task automatic test_door_cycle();
    send_item(1'b0, KEY_OPEN);
    send_code(dir_code);
    send_item(1'b0, KEY_OPEN);
    send_item(KIND_TICK, 8'hFF);
    send_item(1'b0, KEY_CLOSE);
  endtask

  // random sequences under several settings, extremes included
  task automatic test_random_phases();
    logic [15:0] ticks;
    logic [3:0]  att;
    int          pct_good;
    int          counted;
    bit          m;
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      pct_good = 60;
      case (ph)
        0: begin
          ticks    = 16'd1;
          att      = 4'd15;
          pct_good = 15;  // long runs of misses to reach the top limit
        end
        1: begin
          ticks = 16'd0;
          att   = 4'd0;   // alarm on the first wrong code
        end
        2: begin
          ticks = 16'd3;
          att   = 4'd1;
        end
        3: begin
          ticks = 16'($urandom_range(2, 20));
          att   = 4'($urandom_range(1, 15));
        end
        default: begin
          ticks = 16'd5;
          att   = ATT_RESET;
        end
      endcase
      cfg_apply(ticks, att);
      steady_flow = (ph == 2);
      counted     = 0;
      while (counted < 90) begin
        random_item(pct_good, m);
        if (m) counted++;
      end
      steady_flow = 1'b0;
    end
  endtask

  // longest lockout: a failed check loads the top tick count, and the alarm
  // holds through a run of ticks and ignored keys
  task automatic test_long_lockout();
    bit m;
    drain_results();
    cfg_apply(16'hFFFF, 4'd1);
    do random_item(0, m); while (!(lock_st == M_ALARM && alarm_left == 32'hFFFF));
    repeat (24) random_item(0, m);
  endtask

  initial begin
    lock_mirror_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_setup_and_retry();
    test_zero_lockout();
    test_door_cycle();
    test_random_phases();
    test_long_lockout();

    drain_results();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/kcl_pkg.sv
hdl/kcl_cfg.sv
hdl/kcl_core.sv
hdl/keypad_code_lock_controller.sv
tb/tb_keypad_code_lock_controller.sv
